// File: rtl/azsc_pkg.sv
// ----------------------------------------------------------------------------
// azsc_pkg
// shared types and constants for the affine zoom shortcut classifier
// ----------------------------------------------------------------------------
package azsc_pkg;

   localparam int ZOOM_W = 16;
   localparam int POS_ZMAX = 32767;
   localparam int NEG_ZMAX = 32768;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_MULT = 2'd1,
      KIND_DIV  = 2'd2
   } kind_type;

   // per-axis outcome of the front classification
   typedef struct packed {
      logic              neg;
      logic              unity;
      logic              mul_path;
      logic              div_try;
      logic [ZOOM_W-1:0] mul_z;
   } axis_pre_type;

   typedef struct packed {
      logic         aligned;
      logic         swapped;
      axis_pre_type ax;
      axis_pre_type ay;
   } front_type;

   typedef struct packed {
      kind_type          kind;
      logic [ZOOM_W-1:0] z;
   } axis_res_type;

endpackage

// File: rtl/azsc_front.sv
// ----------------------------------------------------------------------------
// azsc_front
// splits coefficients, finds the transform class and runs the unity and
// integer multiple tests for both axis zooms
// ----------------------------------------------------------------------------
module azsc_front #(
   parameter int FRAC_BITS = 16,
   parameter int COEF_BITS = 32
) (
   input  logic signed [31:0]     xin_to_xout,
   input  logic signed [31:0]     yin_to_xout,
   input  logic signed [31:0]     xin_to_yout,
   input  logic signed [31:0]     yin_to_yout,
   output azsc_pkg::front_type    entry,
   output logic [COEF_BITS-1:0]   mag_x,
   output logic [COEF_BITS-1:0]   mag_y
);

   localparam int C = COEF_BITS;
   localparam int EW = COEF_BITS + 2;
   localparam int TOL = ((1 << FRAC_BITS) + 9999) / 10000;
   localparam longint NEG_LIM = ((longint'(1) << FRAC_BITS) * 9999) / 10000;
   localparam logic [EW-1:0] ONE_E = EW'(1) << FRAC_BITS;
   localparam logic [EW-1:0] HALF_E = ONE_E >> 1;
   localparam logic [EW-1:0] TOL_E = EW'(TOL);
   localparam logic [EW-1:0] NLIM_E = EW'(NEG_LIM);

   logic signed [31:0] raw [4];
   logic [C-1:0]       cf [4];
   logic               neg [4];
   logic [C-1:0]       mag [4];
   logic               near_zero [4];
   logic               aligned, swapped, act;
   logic               an [2];
   logic [C-1:0]       am [2];
   azsc_pkg::axis_pre_type pre [2];

   assign raw[0] = xin_to_xout;
   assign raw[1] = yin_to_xout;
   assign raw[2] = xin_to_yout;
   assign raw[3] = yin_to_yout;

   for (genvar i = 0; i < 4; i++) begin : g_coef
      if (C <= 32) begin : g_cut
         assign cf[i] = raw[i][C-1:0];
      end else begin : g_ext
         assign cf[i] = {{(C-32){raw[i][31]}}, raw[i]};
      end
      assign neg[i] = cf[i][C-1];
      assign mag[i] = neg[i] ? (~cf[i] + C'(1)) : cf[i];
      assign near_zero[i] = mag[i] < C'(TOL);
   end

   assign aligned = near_zero[1] && near_zero[2];
   assign swapped = !aligned && near_zero[0] && near_zero[3];
   assign act = aligned || swapped;

   assign an[0] = aligned ? neg[0] : neg[1];
   assign am[0] = aligned ? mag[0] : mag[1];
   assign an[1] = aligned ? neg[3] : neg[2];
   assign am[1] = aligned ? mag[3] : mag[2];

   for (genvar a = 0; a < 2; a++) begin : g_axis
      logic [EW-1:0] me, d1, n, nsh, dn, lim;
      logic          unity, mpath, nok;
      assign me = EW'(am[a]);
      assign d1 = (me > ONE_E) ? me - ONE_E : ONE_E - me;
      assign unity = !an[a] && (d1 < TOL_E);
      assign mpath = (!an[a] && me > ONE_E) || (an[a] && me > NLIM_E);
      assign n = (me + HALF_E) >> FRAC_BITS;
      assign nsh = n << FRAC_BITS;
      assign dn = (me > nsh) ? me - nsh : nsh - me;
      assign lim = an[a] ? EW'(azsc_pkg::NEG_ZMAX) : EW'(azsc_pkg::POS_ZMAX);
      assign nok = (n != '0) && (n <= lim) && (dn < TOL_E);
      always_comb begin
         pre[a].neg = an[a];
         pre[a].unity = act && unity;
         pre[a].mul_path = act && !unity && mpath;
         pre[a].div_try = act && !unity && !mpath && (me != '0);
         pre[a].mul_z = '0;
         if (nok) begin
            pre[a].mul_z = an[a] ? azsc_pkg::ZOOM_W'(-n) : azsc_pkg::ZOOM_W'(n);
         end
      end
   end

   assign entry.aligned = aligned;
   assign entry.swapped = swapped;
   assign entry.ax = pre[0];
   assign entry.ay = pre[1];
   assign mag_x = am[0];
   assign mag_y = am[1];

endmodule

// File: rtl/azsc_queue.sv
// ----------------------------------------------------------------------------
// azsc_queue
// two-entry fifo between classification front and reciprocal back
// ----------------------------------------------------------------------------
module azsc_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wp_ff, rp_ff;
   logic [1:0]       cnt_ff;
   logic             push, pop;

   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_data = mem_ff[rp_ff];
   assign push = wr_valid && wr_ready;
   assign pop = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wp_ff] <= wr_data;
   end

endmodule

// File: rtl/azsc_back.sv
// ----------------------------------------------------------------------------
// azsc_back
// pipelined restoring reciprocal for both axes, reciprocal match test,
// shortcut decision and result register
// ----------------------------------------------------------------------------
module azsc_back #(
   parameter int FRAC_BITS = 16,
   parameter int COEF_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  azsc_pkg::front_type   in_entry,
   input  logic [COEF_BITS-1:0]  in_mag_x,
   input  logic [COEF_BITS-1:0]  in_mag_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_axis_aligned,
   output logic                  rsp_axes_swapped,
   output logic                  rsp_integer_ok,
   output logic                  rsp_use_multiply,
   output logic                  rsp_scaled,
   output logic signed [15:0]    rsp_x_zoom_int,
   output logic signed [15:0]    rsp_y_zoom_int
);

   localparam int C = COEF_BITS;
   localparam int QW = 2 * FRAC_BITS + 1;
   localparam int RW = COEF_BITS + 1;
   localparam int QXW = ((QW > C) ? QW : C) + 2;
   localparam int TOL = ((1 << FRAC_BITS) + 9999) / 10000;
   localparam logic [QXW-1:0] HALF_E = QXW'(1) << (FRAC_BITS - 1);
   localparam logic [QXW-1:0] RMAX_E = (QXW'(1) << (C - 1)) - QXW'(1);

   logic                adv;
   logic                vld_ff [QW];
   azsc_pkg::front_type ent_ff [QW];
   logic [RW-1:0]       rx_ff [QW], ry_ff [QW];
   logic [QW-1:0]       qx_ff [QW], qy_ff [QW];
   logic [C-1:0]        mx_ff [QW], my_ff [QW];

   logic                nv [QW];
   azsc_pkg::front_type ne [QW];
   logic [RW-1:0]       nrx [QW], nry [QW];
   logic [QW-1:0]       nqx [QW], nqy [QW];
   logic [C-1:0]        nmx [QW], nmy [QW];

   logic                rsp_valid_ff;

   assign adv = !rsp_valid_ff || rsp_ready;
   assign in_ready = adv;

   // one quotient bit per stage; the dividend's only set bit enters at stage 0
   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic                pv;
      azsc_pkg::front_type pe;
      logic [RW-1:0]       px, py, sx, sy;
      logic [QW-1:0]       pqx, pqy;
      logic [C-1:0]        pmx, pmy;
      logic                gx, gy;
      if (k == 0) begin : g_first
         assign pv = in_valid;
         assign pe = in_entry;
         assign px = '0;
         assign py = '0;
         assign pqx = '0;
         assign pqy = '0;
         assign pmx = in_mag_x;
         assign pmy = in_mag_y;
         assign sx = {px[RW-2:0], 1'b1};
         assign sy = {py[RW-2:0], 1'b1};
      end else begin : g_next
         assign pv = vld_ff[k-1];
         assign pe = ent_ff[k-1];
         assign px = rx_ff[k-1];
         assign py = ry_ff[k-1];
         assign pqx = qx_ff[k-1];
         assign pqy = qy_ff[k-1];
         assign pmx = mx_ff[k-1];
         assign pmy = my_ff[k-1];
         assign sx = {px[RW-2:0], 1'b0};
         assign sy = {py[RW-2:0], 1'b0};
      end
      assign gx = sx >= {1'b0, pmx};
      assign gy = sy >= {1'b0, pmy};
      assign nv[k] = pv;
      assign ne[k] = pe;
      assign nrx[k] = gx ? sx - {1'b0, pmx} : sx;
      assign nry[k] = gy ? sy - {1'b0, pmy} : sy;
      assign nqx[k] = {pqx[QW-2:0], gx};
      assign nqy[k] = {pqy[QW-2:0], gy};
      assign nmx[k] = pmx;
      assign nmy[k] = pmy;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QW; k++) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= nv[k];
         end
         if (adv) begin
            ent_ff[k] <= ne[k];
            rx_ff[k] <= nrx[k];
            ry_ff[k] <= nry[k];
            qx_ff[k] <= nqx[k];
            qy_ff[k] <= nqy[k];
            mx_ff[k] <= nmx[k];
            my_ff[k] <= nmy[k];
         end
      end
   end

   function automatic azsc_pkg::axis_res_type eval_axis(
      input azsc_pkg::axis_pre_type p,
      input logic [QW-1:0] q
   );
      logic [QXW-1:0] qe, n, nsh, d, lim;
      logic           hit;
      azsc_pkg::axis_res_type r;
      qe = QXW'(q);
      n = (qe + HALF_E) >> FRAC_BITS;
      nsh = n << FRAC_BITS;
      d = (qe > nsh) ? qe - nsh : nsh - qe;
      lim = p.neg ? QXW'(azsc_pkg::NEG_ZMAX) : QXW'(azsc_pkg::POS_ZMAX);
      // saturated reciprocal fails
      hit = (qe < RMAX_E) && (n != '0) && (n <= lim) && (d < QXW'(TOL));
      r.kind = azsc_pkg::KIND_NONE;
      r.z = '0;
      if (p.unity) begin
         r.z = azsc_pkg::ZOOM_W'(1);
      end else if (p.mul_path) begin
         r.z = p.mul_z;
         if (p.mul_z != '0) r.kind = azsc_pkg::KIND_MULT;
      end else if (p.div_try && hit) begin
         r.z = p.neg ? azsc_pkg::ZOOM_W'(-n) : azsc_pkg::ZOOM_W'(n);
         r.kind = azsc_pkg::KIND_DIV;
      end else begin
         r.z = '0;
      end
      return r;
   endfunction

   azsc_pkg::front_type    le;
   azsc_pkg::axis_res_type resx, resy;
   logic                   ok_in, mult_in, scaled_in;

   assign le = ent_ff[QW-1];
   assign resx = eval_axis(le.ax, qx_ff[QW-1]);
   assign resy = eval_axis(le.ay, qy_ff[QW-1]);

   always_comb begin
      ok_in = 1'b0;
      mult_in = 1'b0;
      scaled_in = 1'b0;
      if ((le.aligned || le.swapped) && resx.z != '0 && resy.z != '0) begin
         if (resx.z == azsc_pkg::ZOOM_W'(1) && resy.z == azsc_pkg::ZOOM_W'(1)) begin
            ok_in = 1'b1;
         end else if (resx.kind != azsc_pkg::KIND_DIV && resy.kind != azsc_pkg::KIND_DIV) begin
            ok_in = 1'b1;
            mult_in = 1'b1;
            scaled_in = 1'b1;
         end else if (resx.kind != azsc_pkg::KIND_MULT
                      && resy.kind != azsc_pkg::KIND_MULT) begin
            ok_in = 1'b1;
            scaled_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[QW-1];
      end
      if (adv) begin
         rsp_axis_aligned <= le.aligned;
         rsp_axes_swapped <= le.swapped;
         rsp_integer_ok <= ok_in;
         rsp_use_multiply <= mult_in;
         rsp_scaled <= scaled_in;
         rsp_x_zoom_int <= resx.z;
         rsp_y_zoom_int <= resy.z;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/affine_zoom_shortcut_classifier.sv
// ----------------------------------------------------------------------------
// affine_zoom_shortcut_classifier
// classifies a 2d affine transform and finds integer zoom shortcuts
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | beat contents
//   req_    | in        | req_valid/req_ready  | four signed coefficients
//   rsp_    | out       | rsp_valid/rsp_ready  | class flags and zoom factors
//
// one beat per cycle sustained while rsp_ is not stalled; results pass
// through the reciprocal pipeline (2*FRAC_BITS+1 stages, one quotient bit
// each, the first loaded straight from the queue head) and then the
// result register
// reset is synchronous and clears only valid and pointer state
// an rsp_ stall freezes the back pipeline; the two-entry queue keeps
// req_ready high until it fills
//
module affine_zoom_shortcut_classifier #(
   parameter int FRAC_BITS = 16,
   parameter int COEF_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_xin_to_xout,
   input  logic signed [31:0] req_yin_to_xout,
   input  logic signed [31:0] req_xin_to_yout,
   input  logic signed [31:0] req_yin_to_yout,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_axis_aligned,
   output logic               rsp_axes_swapped,
   output logic               rsp_integer_ok,
   output logic               rsp_use_multiply,
   output logic               rsp_scaled,
   output logic signed [15:0] rsp_x_zoom_int,
   output logic signed [15:0] rsp_y_zoom_int
);

   localparam int FW = $bits(azsc_pkg::front_type);
   localparam int QDW = FW + 2 * COEF_BITS;

   // front outputs
   azsc_pkg::front_type    f_entry;
   logic [COEF_BITS-1:0]   f_mag_x, f_mag_y;

   // queue head
   logic                   q_valid, q_ready;
   logic [QDW-1:0]         q_data;
   azsc_pkg::front_type    q_entry;
   logic [COEF_BITS-1:0]   q_mag_x, q_mag_y;

   // class test, unity and integer multiple checks
   azsc_front #(
      .FRAC_BITS(FRAC_BITS),
      .COEF_BITS(COEF_BITS)
   ) u_front (
      .xin_to_xout (req_xin_to_xout),
      .yin_to_xout (req_yin_to_xout),
      .xin_to_yout (req_xin_to_yout),
      .yin_to_yout (req_yin_to_yout),
      .entry       (f_entry),
      .mag_x       (f_mag_x),
      .mag_y       (f_mag_y)
   );

   // decouples the front from back pressure
   azsc_queue #(
      .WIDTH(QDW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_valid),
      .wr_ready (req_ready),
      .wr_data  ({f_entry, f_mag_x, f_mag_y}),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_data  (q_data)
   );

   assign q_entry = q_data[QDW-1 -: FW];
   assign q_mag_x = q_data[2*COEF_BITS-1 -: COEF_BITS];
   assign q_mag_y = q_data[COEF_BITS-1:0];

   // reciprocal pipeline, divide match and final decision
   azsc_back #(
      .FRAC_BITS(FRAC_BITS),
      .COEF_BITS(COEF_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (q_valid),
      .in_ready         (q_ready),
      .in_entry         (q_entry),
      .in_mag_x         (q_mag_x),
      .in_mag_y         (q_mag_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_axis_aligned (rsp_axis_aligned),
      .rsp_axes_swapped (rsp_axes_swapped),
      .rsp_integer_ok   (rsp_integer_ok),
      .rsp_use_multiply (rsp_use_multiply),
      .rsp_scaled       (rsp_scaled),
      .rsp_x_zoom_int   (rsp_x_zoom_int),
      .rsp_y_zoom_int   (rsp_y_zoom_int)
   );

endmodule

// File: rtl/azsc_checker.sv
// ----------------------------------------------------------------------------
// azsc_checker
// port-level checks on the classifier results
// ----------------------------------------------------------------------------
module azsc_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_axis_aligned,
   input logic               rsp_axes_swapped,
   input logic               rsp_integer_ok,
   input logic               rsp_use_multiply,
   input logic               rsp_scaled,
   input logic signed [15:0] rsp_x_zoom_int,
   input logic signed [15:0] rsp_y_zoom_int
);

   // a stalled result stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_axis_aligned && rsp_axes_swapped))
      else $error("aligned and swapped together");

   // general transform gives nothing
   a_general: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_axis_aligned && !rsp_axes_swapped |->
         !rsp_integer_ok && rsp_x_zoom_int == 16'sd0 && rsp_y_zoom_int == 16'sd0)
      else $error("general transform reported a shortcut");

   a_mult: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_use_multiply || rsp_scaled) |-> rsp_integer_ok)
      else $error("scaling flag without shortcut");

   // unscaled shortcut means unity on both axes
   a_unity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_integer_ok && !rsp_scaled |->
         rsp_x_zoom_int == 16'sd1 && rsp_y_zoom_int == 16'sd1)
      else $error("unscaled shortcut with non-unity zoom");

endmodule

bind affine_zoom_shortcut_classifier azsc_checker u_azsc_checker (.*);

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the affine zoom shortcut classifier against a behavioral predictor
// on directed corner transforms, random near-integer zoom transforms and fully random ones
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;
   localparam longint ONE = 64'd1 << FRAC;
   localparam longint HALF = ONE >> 1;
   localparam longint TOL = (ONE + 9999) / 10000;
   localparam longint NEG_LIM = (ONE * 9999) / 10000;
   localparam longint SIGN_BIT = 64'd1 << 31;
   localparam longint RECIP_MAX = SIGN_BIT - 1;
   localparam int LIMIT = 400000;

   typedef struct packed {
      logic        aligned;
      logic        swapped;
      logic        ok;
      logic        mult;
      logic        scaled;
      logic [15:0] zx;
      logic [15:0] zy;
   } verdict_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [31:0] req_xin_to_xout = 0, req_yin_to_xout = 0;
   logic signed [31:0] req_xin_to_yout = 0, req_yin_to_yout = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic rsp_axis_aligned, rsp_axes_swapped, rsp_integer_ok, rsp_use_multiply;
   logic rsp_scaled;
   logic signed [15:0] rsp_x_zoom_int, rsp_y_zoom_int;

   verdict_type verdicts_due[$];
   int errors = 0;
   int cycles = 0;

   affine_zoom_shortcut_classifier u_top (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // cycle limit guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // tolerance compare on magnitudes
   function automatic bit near(longint a, longint b);
      return ((a > b) ? a - b : b - a) < TOL;
   endfunction

   function automatic longint round_fit(longint mag, bit neg);
      longint n;
      n = (mag + HALF) >> FRAC;
      if (n > (neg ? 32768 : 32767)) return 0;
      if (!near(mag, n * ONE)) return 0;
      return n;
   endfunction

   // kind: 1 multiply, 0 unity or miss, -1 divide
   function automatic int zoom_kind(logic [31:0] raw, output int z);
      bit neg;
      longint mag, n, q;
      neg = raw[31];
      mag = neg ? ((~{32'd0, raw} + 1) & 64'hFFFF_FFFF) : {32'd0, raw};
      z = 0;
      if (!neg && near(mag, ONE)) begin
         z = 1;
         return 0;
      end
      if ((!neg && mag > ONE) || (neg && mag > NEG_LIM)) begin
         n = round_fit(mag, neg);
         if (n == 0) return 0;
         z = neg ? -int'(n) : int'(n);
         return 1;
      end
      if (mag == 0) return 0;
      q = (ONE * ONE) / mag;
      if (q >= RECIP_MAX) return 0;
      n = round_fit(q, neg);
      if (n == 0) return 0;
      z = neg ? -int'(n) : int'(n);
      return -1;
   endfunction

   function automatic longint mag_of(logic [31:0] raw);
      return raw[31] ? ((~{32'd0, raw} + 1) & 64'hFFFF_FFFF) : {32'd0, raw};
   endfunction

   function automatic verdict_type classify(logic [31:0] xx, logic [31:0] yx,
                                            logic [31:0] xy, logic [31:0] yy);
      verdict_type v;
      int kx, ky, zx, zy;
      v = '0;
      kx = 0; ky = 0; zx = 0; zy = 0;
      if (mag_of(yx) < TOL && mag_of(xy) < TOL) begin
         v.aligned = 1;
         kx = zoom_kind(xx, zx);
         ky = zoom_kind(yy, zy);
      end else if (mag_of(xx) < TOL && mag_of(yy) < TOL) begin
         v.swapped = 1;
         kx = zoom_kind(yx, zx);
         ky = zoom_kind(xy, zy);
      end
      if ((v.aligned || v.swapped) && zx != 0 && zy != 0) begin
         if (zx == 1 && zy == 1) v.ok = 1;
         else if (kx >= 0 && ky >= 0) begin
            v.ok = 1; v.mult = 1; v.scaled = 1;
         end else if (kx <= 0 && ky <= 0) begin
            v.ok = 1; v.scaled = 1;
         end
      end
      v.zx = zx[15:0];
      v.zy = zy[15:0];
      return v;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // valid stays high across back to back beats; it drops only for a gap
   task automatic send_beat(logic [31:0] xx, logic [31:0] yx,
                            logic [31:0] xy, logic [31:0] yy);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_xin_to_xout <= xx;
      req_yin_to_xout <= yx;
      req_xin_to_yout <= xy;
      req_yin_to_yout <= yy;
      verdicts_due.push_back(classify(xx, yx, xy, yy));
      do @(posedge clock); while (!req_ready);
   endtask

   // result side: random stalls, compare each beat with the oldest verdict
   always @(posedge clock) begin
      verdict_type want, got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_axis_aligned, rsp_axes_swapped, rsp_integer_ok,
                   rsp_use_multiply, rsp_scaled, rsp_x_zoom_int, rsp_y_zoom_int};
            if (verdicts_due.size() == 0) begin
               $display("%0t unexpected beat %h", $time, got);
               errors++;
            end else begin
               want = verdicts_due.pop_front();
               if (want.aligned != got.aligned)
                  $display("%0t aligned exp %b got %b", $time, want.aligned, got.aligned);
               if (want.swapped != got.swapped)
                  $display("%0t swapped exp %b got %b", $time, want.swapped, got.swapped);
               if (want.ok != got.ok)
                  $display("%0t integer_ok exp %b got %b", $time, want.ok, got.ok);
               if (want.mult != got.mult)
                  $display("%0t use_multiply exp %b got %b", $time, want.mult, got.mult);
               if (want.scaled != got.scaled)
                  $display("%0t scaled exp %b got %b", $time, want.scaled, got.scaled);
               if (want.zx != got.zx)
                  $display("%0t x_zoom exp %0d got %0d", $time, $signed(want.zx),
                           $signed(got.zx));
               if (want.zy != got.zy)
                  $display("%0t y_zoom exp %0d got %0d", $time, $signed(want.zy),
                           $signed(got.zy));
               if (want != got) errors++;
            end
         end
         // stall pattern: runs of ready, short and occasional long stalls
         if ($urandom_range(0, 99) < 3) rsp_ready <= 0;
         else if (!rsp_ready) rsp_ready <= ($urandom_range(0, 3) == 0);
         else rsp_ready <= ($urandom_range(0, 99) < 80);
      end
   end

   // a zoom near a chosen value: integer, reciprocal, unity, with jitter
   function automatic logic [31:0] zoom_value();
      int r, n;
      longint base;
      logic [31:0] jit;
      r = $urandom_range(0, 9);
      n = $urandom_range(1, 300);
      if ($urandom_range(0, 9) == 0) n = $urandom_range(1, 32768);
      case (r)
         0, 1: base = ONE;
         2, 3, 4: base = longint'(n) * ONE;
         5, 6, 7: base = (ONE + n / 2) / n;
         8: base = -longint'(n) * ONE;
         default: base = -((ONE + n / 2) / n);
      endcase
      if ($urandom_range(0, 1) && base > 0) base = ((ONE * ONE) / base);
      jit = $urandom_range(0, 20) - 10;
      return base[31:0] + jit;
   endfunction

   function automatic logic [31:0] tiny();
      logic [31:0] t;
      t = $urandom_range(0, 16) - 8;
      return t;
   endfunction

   task automatic test_directed();
      send_beat(32'(ONE), 0, 0, 32'(ONE));
      send_beat(32'(2 * ONE), 0, 0, 32'(3 * ONE));
      send_beat(32'(ONE / 2), 0, 0, 32'(ONE / 4));
      send_beat(32'(ONE / 2), 0, 0, 32'(3 * ONE));
      send_beat(0, 32'(ONE), 32'(ONE), 0);
      send_beat(0, 32'(-ONE), 32'(2 * ONE), 0);
      send_beat(32'(ONE), 32'(ONE), 32'(ONE), 32'(ONE));
      send_beat(0, 0, 0, 0);
      send_beat(32'h8000_0000, 0, 0, 32'h8000_0000);
      send_beat(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF);
      send_beat(32'h7FFF_0000, 0, 0, 32'(ONE));
      send_beat(32'h8000_0000, 0, 0, 32'(ONE));
      send_beat(1, 0, 0, 32'(ONE));
      send_beat(-1, 0, 0, 32'(-ONE));
      send_beat(32'(ONE + 6), 6, -6, 32'(ONE - 6));
      send_beat(32'(ONE + 7), 7, 0, 32'(ONE));
      send_beat(32'(-NEG_LIM), 0, 0, 32'(-NEG_LIM - 1));
      send_beat(32'(-ONE / 3), 0, 0, 32'(ONE / 3));
      send_beat(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_beat(32'(ONE * 5 + HALF), 0, 0, 32'(ONE * 4));
      send_beat(21845, 0, 0, 13107);
   endtask

   task automatic test_random();
      int r;
      for (int i = 0; i < 1150; i++) begin
         r = $urandom_range(0, 9);
         if (r < 4) send_beat(zoom_value(), tiny(), tiny(), zoom_value());
         else if (r < 8) send_beat(tiny(), zoom_value(), zoom_value(), tiny());
         else send_beat($urandom, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random();
      req_valid <= 0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (2 * FRAC + 10) @(posedge clock);
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule

// File: files.f
rtl/azsc_pkg.sv
rtl/azsc_front.sv
rtl/azsc_queue.sv
rtl/azsc_back.sv
rtl/affine_zoom_shortcut_classifier.sv
rtl/azsc_checker.sv
sim/tb_top.sv
